>>> sv/apl_pkg.sv
// Shared types, codes and sizes for the address-to-port learning table.
// Used by every module of the block but apl_ram; depends on nothing.
`timescale 1ns / 1ps

package apl_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // match vectors are searched this many slots per cycle
  localparam int SCAN_CHUNK = 32;
  localparam int OFF_W      = $clog2(SCAN_CHUNK);

  localparam logic [OP_W-1:0] OP_LEARN  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

  // classified command handed from the front to the back
  typedef struct packed {
    logic              learn;
    logic              lookup;
    logic              del;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port;
  } cmd_t;

  // offset of the lowest set bit within one chunk
  function automatic logic [OFF_W-1:0] first_set(input logic [SCAN_CHUNK-1:0] v);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = OFF_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

>>> sv/apl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module apl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/apl_front.sv
// Front end: accepts commands, classifies the opcode and queues them.
// Depends on apl_pkg for cmd_t and opcodes.
`timescale 1ns / 1ps

module apl_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [apl_pkg::OP_W-1:0]   op,
  input  logic [apl_pkg::ADDR_W-1:0] address,
  input  logic [apl_pkg::PORT_W-1:0] port,
  output logic                       cmd_valid,
  output apl_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);

  localparam int QD = 2;

  apl_pkg::cmd_t q [QD];
  apl_pkg::cmd_t cmd_in;
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push;
  logic          pop;

  always_comb begin
    cmd_in.learn   = (op == apl_pkg::OP_LEARN);
    cmd_in.lookup  = (op == apl_pkg::OP_LOOKUP);
    cmd_in.del     = (op == apl_pkg::OP_DELETE);
    cmd_in.address = address;
    cmd_in.port    = port;
  end

  assign busy      = (count == 2'(QD));
  assign push      = start && !busy;
  assign pop       = cmd_pop && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

>>> sv/apl_back.sv
// Back end: slot cells with parallel compare, chunked priority scan,
// table update and port readback. Depends on apl_pkg and apl_ram.
`timescale 1ns / 1ps

module apl_back #(
  parameter int ENTRIES = apl_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  apl_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  output logic                         done,
  output logic [apl_pkg::STAT_W-1:0]   status,
  output logic [apl_pkg::PORT_W-1:0]   found_port
);

  localparam int IW     = $clog2(ENTRIES);
  localparam int NCHUNK = (ENTRIES + apl_pkg::SCAN_CHUNK - 1) / apl_pkg::SCAN_CHUNK;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PADW   = NCHUNK * apl_pkg::SCAN_CHUNK;
  localparam int PW     = CW + apl_pkg::OFF_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0]          state;
  apl_pkg::cmd_t       cur;

  logic                        slot_valid [ENTRIES];
  logic [apl_pkg::ADDR_W-1:0]  slot_address [ENTRIES];
  logic [apl_pkg::PORT_W-1:0]  slot_port [ENTRIES];

  logic [PADW-1:0] amatch, pmatch, freev;
  logic [PADW-1:0] vec_a, vec_b;
  logic [CW-1:0]   ci;
  logic            hit_a, hit_b;
  logic [IW-1:0]   idx_a, idx_b;

  logic [apl_pkg::SCAN_CHUNK-1:0] chunk_a, chunk_b;
  logic [PW-1:0]                  pos_a, pos_b;
  logic [PW-1:0]                  base;

  logic                       upd_port;
  logic                       upd_insert;
  logic                       upd_clear;
  logic [IW-1:0]              wr_idx;
  logic [apl_pkg::PORT_W-1:0] ram_rdata;

  // per-slot compare against the current key
  always_comb begin
    amatch = '0;
    pmatch = '0;
    freev  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      amatch[i] = slot_valid[i] && (slot_address[i] == cur.address);
      pmatch[i] = slot_valid[i] && (slot_port[i] == cur.port);
      freev[i]  = !slot_valid[i];
    end
  end

  assign base    = {ci, apl_pkg::OFF_W'(0)};
  assign chunk_a = vec_a[base +: apl_pkg::SCAN_CHUNK];
  assign chunk_b = vec_b[base +: apl_pkg::SCAN_CHUNK];
  assign pos_a   = {ci, apl_pkg::first_set(chunk_a)};
  assign pos_b   = {ci, apl_pkg::first_set(chunk_b)};

  assign cmd_pop = (state == S_IDLE) && cmd_valid;

  // table updates happen in the execute state only
  always_comb begin
    upd_port   = 1'b0;
    upd_insert = 1'b0;
    upd_clear  = 1'b0;
    wr_idx     = idx_a;
    if (state == S_EXEC) begin
      if (cur.learn) begin
        if (hit_a) begin
          upd_port = 1'b1;
        end else if (hit_b) begin
          upd_insert = 1'b1;
          wr_idx     = idx_b;
        end
      end else if (cur.del && hit_a) begin
        upd_clear = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (wr_idx == IW'(i)) begin
          if (upd_insert) begin
            slot_valid[i] <= 1'b1;
          end else if (upd_clear) begin
            slot_valid[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_idx == IW'(i)) begin
        if (upd_insert) begin
          slot_address[i] <= cur.address;
        end
        if (upd_insert || upd_port) begin
          slot_port[i] <= cur.port;
        end
      end
    end
  end

  // copy of the ports for readback at the matched slot
  apl_ram #(
    .WIDTH (apl_pkg::PORT_W),
    .DEPTH (ENTRIES)
  ) u_port_ram (
    .clk   (clk),
    .we    (upd_insert || upd_port),
    .waddr (wr_idx),
    .wdata (cur.port),
    .raddr (idx_a),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (ci == CW'(NCHUNK - 1)) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cur.lookup && hit_a) begin
            state <= S_READ;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_READ: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur <= cmd;
        end
      end
      S_CMP: begin
        vec_a <= cur.del ? pmatch : amatch;
        vec_b <= freev;
        ci    <= '0;
        hit_a <= 1'b0;
        hit_b <= 1'b0;
      end
      S_SCAN: begin
        // lowest chunk wins, so keep the first hit
        if (!hit_a && (|chunk_a)) begin
          hit_a <= 1'b1;
          idx_a <= pos_a[IW-1:0];
        end
        if (!hit_b && (|chunk_b)) begin
          hit_b <= 1'b1;
          idx_b <= pos_b[IW-1:0];
        end
        ci <= ci + CW'(1);
      end
      S_EXEC: begin
        found_port <= '0;
        if (cur.learn) begin
          if (hit_a) begin
            status <= apl_pkg::ST_HIT;
          end else if (hit_b) begin
            status <= apl_pkg::ST_INSERTED;
          end else begin
            status <= apl_pkg::ST_FULL;
          end
        end else if ((cur.lookup || cur.del) && hit_a) begin
          status <= apl_pkg::ST_HIT;
        end else begin
          status <= apl_pkg::ST_MISS;
        end
      end
      S_READ: begin
        found_port <= ram_rdata;
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule

>>> sv/address_to_port_learning_table.sv
// Top level of the address-to-port learning table.
// Depends on apl_pkg, apl_front, apl_back and apl_ram.
//
//   channel   signals                        handshake
//   --------  -----------------------------  ----------------------------------
//   command   op, address, port              taken when start && !busy
//   result    status, found_port             valid for one cycle while done
//
// From the queue to its result a command passes dequeue, parallel compare of
// all slots, the priority scan in 32-slot chunks and execute; a lookup hit
// adds a port RAM read. The scan over the match vectors grows with ENTRIES.
// A two-deep command queue keeps start taken while the back end works; busy
// rises when it is full.
// Synchronous reset clears all slots and the queue at once.
// Results cannot be stalled: each is shown once, on the cycle done is high.
`timescale 1ns / 1ps

module address_to_port_learning_table #(
  parameter int ENTRIES = apl_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [apl_pkg::OP_W-1:0]   op,
  input  logic [apl_pkg::ADDR_W-1:0] address,
  input  logic [apl_pkg::PORT_W-1:0] port,
  output logic                       done,
  output logic [apl_pkg::STAT_W-1:0] status,
  output logic [apl_pkg::PORT_W-1:0] found_port
);

  logic          cmd_valid;
  logic          cmd_pop;
  apl_pkg::cmd_t cmd;

  apl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .address   (address),
    .port      (port),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  apl_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .done       (done),
    .status     (status),
    .found_port (found_port)
  );

endmodule

>>> tb/address_to_port_learning_table_checker.sv
// Checker for the address-to-port learning table: watches command and result channels,
// keeps its own copy of the slot table, predicts each answer and compares in order.
// Depends on apl_pkg for widths and op/status codes.
`timescale 1ns / 1ps

module address_to_port_learning_table_checker #(
  parameter int ENTRIES = apl_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [apl_pkg::OP_W-1:0]   op,
  input  logic [apl_pkg::ADDR_W-1:0] address,
  input  logic [apl_pkg::PORT_W-1:0] port,
  input  logic                       done,
  input  logic [apl_pkg::STAT_W-1:0] status,
  input  logic [apl_pkg::PORT_W-1:0] found_port,
  output int                         mismatches,
  output int                         outstanding
);

  typedef struct packed {
    logic [apl_pkg::STAT_W-1:0] status;
    logic [apl_pkg::PORT_W-1:0] found;
  } answer_t;

  logic                       slot_used   [ENTRIES];
  logic [apl_pkg::ADDR_W-1:0] slot_addr   [ENTRIES];
  logic [apl_pkg::PORT_W-1:0] slot_handle [ENTRIES];

  answer_t pending_answers[$];

  task automatic report(input string what, input logic [apl_pkg::PORT_W-1:0] got,
                        input logic [apl_pkg::PORT_W-1:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one command to the table copy and return the answer it must produce.
  function automatic answer_t apply_command(input logic [apl_pkg::OP_W-1:0] code,
                                            input logic [apl_pkg::ADDR_W-1:0] key,
                                            input logic [apl_pkg::PORT_W-1:0] handle);
    answer_t ans;
    int      hit;
    int      free;
    ans.status = apl_pkg::ST_MISS;
    ans.found  = '0;
    hit  = -1;
    free = -1;
    case (code)
      apl_pkg::OP_LEARN: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit < 0 && slot_used[i] && slot_addr[i] == key) hit = i;
          if (free < 0 && !slot_used[i]) free = i;
        end
        if (hit >= 0) begin
          slot_handle[hit] = handle;
          ans.status = apl_pkg::ST_HIT;
        end else if (free >= 0) begin
          slot_used[free]   = 1'b1;
          slot_addr[free]   = key;
          slot_handle[free] = handle;
          ans.status = apl_pkg::ST_INSERTED;
        end else begin
          ans.status = apl_pkg::ST_FULL;
        end
      end
      apl_pkg::OP_LOOKUP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit < 0 && slot_used[i] && slot_addr[i] == key) hit = i;
        end
        if (hit >= 0) begin
          ans.status = apl_pkg::ST_HIT;
          ans.found  = slot_handle[hit];
        end
      end
      apl_pkg::OP_DELETE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit < 0 && slot_used[i] && slot_handle[i] == handle) hit = i;
        end
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          ans.status = apl_pkg::ST_HIT;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      pending_answers.delete();
      mismatches = 0;
    end else begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          report("unexpected result status", apl_pkg::PORT_W'(status), '0);
        end else begin
          want = pending_answers.pop_front();
          if (status !== want.status) begin
            report("status", apl_pkg::PORT_W'(status), apl_pkg::PORT_W'(want.status));
          end
          if (found_port !== want.found) report("found_port", found_port, want.found);
        end
      end
      if (start && !busy) begin
        pending_answers.push_back(apply_command(op, address, port));
      end
    end
    outstanding = pending_answers.size();
  end

endmodule

>>> tb/address_to_port_learning_table_test.sv
// Top of the learning-table testbench: clock, reset, command stimulus and verdict.
// Depends on apl_pkg, address_to_port_learning_table and the checker module.
`timescale 1ns / 1ps

module address_to_port_learning_table_test;

  localparam logic [apl_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HISTORY_MAX  = 128;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [apl_pkg::OP_W-1:0]   op = '0;
  logic [apl_pkg::ADDR_W-1:0] address = '0;
  logic [apl_pkg::PORT_W-1:0] port = '0;
  logic                       done;
  logic [apl_pkg::STAT_W-1:0] status;
  logic [apl_pkg::PORT_W-1:0] found_port;
  int                         mismatches;
  int                         outstanding;

  logic [apl_pkg::ADDR_W-1:0] seen_addrs[$];
  logic [apl_pkg::PORT_W-1:0] seen_ports[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  address_to_port_learning_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .address(address), .port(port),
    .done(done), .status(status), .found_port(found_port)
  );

  address_to_port_learning_table_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .address(address), .port(port),
    .done(done), .status(status), .found_port(found_port),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Idle for the given gap, then present the command and hold it until taken.
  task automatic send(input logic [apl_pkg::OP_W-1:0] code,
                      input logic [apl_pkg::ADDR_W-1:0] key,
                      input logic [apl_pkg::PORT_W-1:0] handle, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    op      <= code;
    address <= key;
    port    <= handle;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [apl_pkg::ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? '1 : '0;
    if (r <= 5 && seen_addrs.size() > 0)
      return seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [apl_pkg::PORT_W-1:0] pick_port();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r <= 11 && seen_ports.size() > 0)
      return seen_ports[$urandom_range(0, seen_ports.size() - 1)];
    return apl_pkg::PORT_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [apl_pkg::OP_W-1:0] pick_op(input phase_t ph);
    int r;
    int t_learn;
    int t_lookup;
    int t_delete;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        t_learn  = 85;
        t_lookup = 95;
        t_delete = 98;
      end
      PH_DRAIN: begin
        t_learn  = 15;
        t_lookup = 30;
        t_delete = 97;
      end
      default: begin
        t_learn  = 40;
        t_lookup = 75;
        t_delete = 95;
      end
    endcase
    if (r < t_learn) return apl_pkg::OP_LEARN;
    if (r < t_lookup) return apl_pkg::OP_LOOKUP;
    if (r < t_delete) return apl_pkg::OP_DELETE;
    return OP_SPARE;
  endfunction

  // stimulus
  initial begin
    logic [apl_pkg::OP_W-1:0]   code;
    logic [apl_pkg::ADDR_W-1:0] key;
    logic [apl_pkg::PORT_W-1:0] handle;
    phase_t                     ph;
    int                         seg_len;
    int                         sent;
    ph      = PH_DRAIN;
    seg_len = 0;
    sent    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (sent < RANDOM_ITEMS) begin
      if (seg_len == 0) begin
        ph = (ph == PH_FILL) ? PH_MIXED : (ph == PH_MIXED) ? PH_DRAIN : PH_FILL;
        seg_len = $urandom_range(80, 240);
      end
      code   = pick_op(ph);
      key    = pick_addr();
      handle = pick_port();
      send(code, key, handle, $urandom_range(0, 19));
      if (code == apl_pkg::OP_LEARN) begin
        seen_addrs.push_back(key);
        seen_ports.push_back(handle);
        if (seen_addrs.size() > HISTORY_MAX) void'(seen_addrs.pop_front());
        if (seen_ports.size() > HISTORY_MAX) void'(seen_ports.pop_front());
      end
      sent++;
      seg_len--;
    end
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
